/* sv/uer_pkg.sv */
package uer_pkg;

    // Field and counter widths
    localparam int TICK_W     = 20;
    localparam int PW_W       = 16;
    localparam int DIST_W     = 14;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ECHO_TO_W  = 16;
    localparam int PERIOD_W   = 20;
    localparam int PRE_TO_W   = 16;

    // Distance scale: mm = width * 343 / 2000, kept as running quotient and remainder
    localparam int ECHO_MUL = 343;
    localparam int ECHO_DIV = 2000;
    localparam int REM_W    = 11;

    // Trigger pulse shape in ticks
    localparam int LOW_TICKS  = 2;
    localparam int HIGH_TICKS = 10;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_STATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID_RESP = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW_TO  = 2'd3;

    typedef struct packed {
        logic                  enabled;
        logic [ECHO_TO_W-1:0]  echo_timeout_us;
        logic [PERIOD_W-1:0]   min_period_us;
        logic [PRE_TO_W-1:0]   pre_low_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic                  trigger_level;
        logic                  done_res;
        logic                  busy_res;
        logic [STATUS_W-1:0]   status;
        logic [DIST_W-1:0]     dist_mm;
    } res_item_t;

endpackage

/* sv/uer_if.sv */
// Input tick channel
interface uer_tick_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic start_request;

    modport source (output valid, output echo_level, output start_request, input ready);
    modport sink   (input valid, input echo_level, input start_request, output ready);
endinterface

// Result channel
interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        done_res;
    logic        busy_res;
    logic [1:0]  status;
    logic [13:0] dist_mm;

    modport source (output valid, output trigger_level, output done_res, output busy_res,
                    output status, output dist_mm, input ready);
    modport sink   (input valid, input trigger_level, input done_res, input busy_res,
                    input status, input dist_mm, output ready);
endinterface

/* sv/uer_cfg_regs.sv */
module uer_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data,
    output uer_pkg::cfg_t                       cfg
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode, data truncated to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLED:    cfg_next.enabled            = cfg_data[0];
                REG_ECHO_TO:    cfg_next.echo_timeout_us    = cfg_data[ECHO_TO_W-1:0];
                REG_MIN_PERIOD: cfg_next.min_period_us      = cfg_data[PERIOD_W-1:0];
                REG_PRE_LOW_TO: cfg_next.pre_low_timeout_us = cfg_data[PRE_TO_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled            <= 1'b0;
            cfg_reg.echo_timeout_us    <= ECHO_TO_W'(30000);
            cfg_reg.min_period_us      <= PERIOD_W'(60000);
            cfg_reg.pre_low_timeout_us <= PRE_TO_W'(1000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/uer_seq.sv */
module uer_seq #(
    parameter int TIMER_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                echo_level,
    input  logic                start_request,
    input  uer_pkg::cfg_t       cfg,
    output uer_pkg::res_item_t  res
);
    import uer_pkg::*;

    localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

    // Phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PRE_LOW   = 3'd1;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd2;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd3;
    localparam logic [2:0] PH_WAIT_RISE = 3'd4;
    localparam logic [2:0] PH_WAIT_FALL = 3'd5;

    logic [2:0]            phase_reg, phase_next;
    logic [TICK_W-1:0]     ticks_reg, ticks_next;
    logic [TIMER_BITS-1:0] since_reg, since_next;
    logic [PW_W-1:0]       pw_reg, pw_next;
    logic [DIST_W-1:0]     quot_reg, quot_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  has_last_reg, has_last_next;
    logic [DIST_W-1:0]     last_reg, last_next;

    logic [2:0]            cur;
    logic                  enter_pre;
    logic                  fail;
    logic [STATUS_W-1:0]   fail_code;
    logic [TICK_W-1:0]     pre_ticks;
    logic                  pw_inc;
    logic [PW_W-1:0]       pw_new;
    logic [REM_W:0]        rem_sum;
    logic                  carry;
    logic [REM_W-1:0]      rem_new;
    logic [DIST_W-1:0]     quot_new;

    // Running width*343/2000: add 343 to the remainder, carry into the quotient
    always_comb
    begin
        pw_inc   = (pw_reg != '1);
        pw_new   = pw_reg + PW_W'(pw_inc);
        rem_sum  = (REM_W+1)'(rem_reg) + (REM_W+1)'(ECHO_MUL);
        carry    = pw_inc && (rem_sum >= (REM_W+1)'(ECHO_DIV));
        rem_new  = pw_inc ? (carry ? REM_W'(rem_sum - (REM_W+1)'(ECHO_DIV)) : REM_W'(rem_sum))
                          : rem_reg;
        quot_new = quot_reg + DIST_W'(carry);
    end

    // Per-tick sequencer
    always_comb
    begin
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        since_next    = (since_reg == '1) ? since_reg : since_reg + TIMER_BITS'(1);
        pw_next       = pw_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        has_last_next = has_last_reg;
        last_next     = last_reg;
        res           = '0;
        enter_pre     = 1'b0;
        fail          = 1'b0;
        fail_code     = ST_TIMEOUT;
        pre_ticks     = ticks_reg;

        cur = phase_reg;
        if (phase_reg > PH_WAIT_FALL)
        begin
            cur        = PH_IDLE;
            phase_next = PH_IDLE;
        end

        // Request screening in idle
        if (cur == PH_IDLE && start_request)
        begin
            if (!cfg.enabled)
            begin
                res.done_res = 1'b1;
                res.status   = ST_INVALID_STATE;
            end
            else if (since_reg != '1 && CMP_W'(since_reg) < CMP_W'(cfg.min_period_us))
            begin
                fail = 1'b1;
            end
            else
            begin
                enter_pre = 1'b1;
                pre_ticks = '0;
            end
        end

        if (enter_pre || cur == PH_PRE_LOW)
        begin
            // Wait for echo low before triggering
            if (!echo_level)
            begin
                res.busy_res = 1'b1;
                phase_next   = PH_TRIG_LOW;
                ticks_next   = '0;
            end
            else if (pre_ticks >= TICK_W'(cfg.pre_low_timeout_us))
            begin
                fail = 1'b1;
            end
            else
            begin
                res.busy_res = 1'b1;
                phase_next   = PH_PRE_LOW;
                ticks_next   = pre_ticks + TICK_W'(1);
            end
        end
        else
        begin
            unique case (cur)
                PH_TRIG_LOW:
                begin
                    res.busy_res = 1'b1;
                    ticks_next   = ticks_reg + TICK_W'(1);
                    if (ticks_next >= TICK_W'(LOW_TICKS))
                    begin
                        phase_next = PH_TRIG_HIGH;
                        ticks_next = '0;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    res.busy_res      = 1'b1;
                    res.trigger_level = 1'b1;
                    ticks_next        = ticks_reg + TICK_W'(1);
                    if (ticks_next >= TICK_W'(HIGH_TICKS))
                    begin
                        phase_next = PH_WAIT_RISE;
                        ticks_next = '0;
                        since_next = '0;
                    end
                end
                PH_WAIT_RISE:
                begin
                    if (echo_level)
                    begin
                        res.busy_res = 1'b1;
                        pw_next      = '0;
                        quot_next    = '0;
                        rem_next     = '0;
                        phase_next   = PH_WAIT_FALL;
                        ticks_next   = '0;
                    end
                    else if (ticks_reg >= TICK_W'(cfg.echo_timeout_us))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        res.busy_res = 1'b1;
                        ticks_next   = ticks_reg + TICK_W'(1);
                    end
                end
                PH_WAIT_FALL:
                begin
                    pw_next   = pw_new;
                    quot_next = quot_new;
                    rem_next  = rem_new;
                    if (!echo_level)
                    begin
                        if (pw_new == '0)
                        begin
                            fail      = 1'b1;
                            fail_code = ST_INVALID_RESP;
                        end
                        else
                        begin
                            last_next     = quot_new;
                            has_last_next = 1'b1;
                            res.done_res  = 1'b1;
                            res.status    = ST_OK;
                            res.dist_mm   = quot_new;
                            phase_next    = PH_IDLE;
                            ticks_next    = '0;
                        end
                    end
                    else if (ticks_reg >= TICK_W'(cfg.echo_timeout_us))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        res.busy_res = 1'b1;
                        ticks_next   = ticks_reg + TICK_W'(1);
                    end
                end
                default:
                begin
                    res.trigger_level = 1'b0;
                end
            endcase
        end

        // Failure: fall back to the held distance when there is one
        if (fail)
        begin
            res.done_res = 1'b1;
            res.busy_res = 1'b0;
            if (has_last_reg)
            begin
                res.status  = ST_OK;
                res.dist_mm = last_reg;
            end
            else
            begin
                res.status  = fail_code;
                res.dist_mm = '0;
            end
            phase_next = PH_IDLE;
            ticks_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            ticks_reg    <= '0;
            since_reg    <= '1;
            pw_reg       <= '0;
            quot_reg     <= '0;
            rem_reg      <= '0;
            has_last_reg <= 1'b0;
            last_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            since_reg    <= since_next;
            pw_reg       <= pw_next;
            quot_reg     <= quot_next;
            rem_reg      <= rem_next;
            has_last_reg <= has_last_next;
            last_reg     <= last_next;
        end
    end

    // A tick never reports done and busy together
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.done_res && res.busy_res))
        else $error("done and busy both set");

    // An ok completion always leaves a held distance behind
    a_ok_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res && res.status == ST_OK |=> has_last_reg)
        else $error("ok completion without held distance");

    // Last trigger-high tick restarts the period timer
    a_trig_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_TRIG_HIGH && ticks_reg == TICK_W'(HIGH_TICKS - 1)
        |=> since_reg == '0)
        else $error("period timer not restarted after trigger");

    // Remainder of the running division stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < REM_W'(ECHO_DIV))
        else $error("distance remainder out of range");

endmodule

/* sv/uer_out_reg.sv */
module uer_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  uer_pkg::res_item_t  item_in,
    input  logic                down_ready,
    output logic                up_ready,
    output logic                valid,
    output uer_pkg::res_item_t  item_out
);
    import uer_pkg::*;

    logic      valid_reg, valid_next;
    res_item_t item_reg;

    // Free when empty or when the held result is taken this cycle
    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

    // A load only happens when the slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || down_ready))
        else $error("result overwritten before being taken");

    // Loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    // Without a load, a taken result leaves the slot empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && down_ready && !load |=> !valid_reg)
        else $error("taken result not released");

endmodule

/* sv/ultrasonic_echo_ranger.sv */
// A tick request accepted at one edge has its result on the output the next cycle.
// Throughput: one tick per cycle while the output register is free; it frees as its result is taken.
// Each accepted tick yields exactly one result; trigger/echo timing counts accepted ticks.
// Reset (rst_n, async, active low): idle, no held distance, period timer saturated,
// registers at enabled=0, echo timeout 30000, min period 60000, pre-low timeout 1000.
module ultrasonic_echo_ranger #(
    parameter int TIMER_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    uer_tick_if.sink                        tick,
    uer_res_if.source                       reading
);
    import uer_pkg::*;

    cfg_t      cfg;
    res_item_t seq_res;
    res_item_t out_item;
    logic      fire;
    logic      up_ready;

    assign fire       = tick.valid && up_ready;
    assign tick.ready = up_ready;

    // Configuration registers
    uer_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Measurement sequencer
    uer_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .echo_level    (tick.echo_level),
        .start_request (tick.start_request),
        .cfg           (cfg),
        .res           (seq_res)
    );

    // Result register
    uer_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .item_in    (seq_res),
        .down_ready (reading.ready),
        .up_ready   (up_ready),
        .valid      (reading.valid),
        .item_out   (out_item)
    );

    assign reading.trigger_level = out_item.trigger_level;
    assign reading.done_res      = out_item.done_res;
    assign reading.busy_res      = out_item.busy_res;
    assign reading.status        = out_item.status;
    assign reading.dist_mm       = out_item.dist_mm;

endmodule
